/* rtl/core/ofnl_pkg.sv */
`timescale 1ns / 1ps
package ofnl_pkg;

	localparam int unsigned LEAF_CAPACITY_DEF = 4096;
	localparam int unsigned MAX_LEVEL = 10;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned IDX_W = 12;
	localparam int unsigned GRID_W = 11;
	localparam int unsigned NFINE = 4;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [2:0] KIND_DONE = 3'd0;
	localparam logic [2:0] KIND_FULL = 3'd1;
	localparam logic [2:0] KIND_OOG = 3'd2;
	localparam logic [2:0] KIND_SAME = 3'd3;
	localparam logic [2:0] KIND_COARSER = 3'd4;
	localparam logic [2:0] KIND_FINER = 3'd5;
	localparam logic [2:0] KIND_NONE = 3'd6;

	localparam logic [1:0] REG_GRID_X = 2'd0;
	localparam logic [1:0] REG_GRID_Y = 2'd1;
	localparam logic [1:0] REG_GRID_Z = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL
	} state_t;

	// probe keys for one request, built ahead of the store scan
	typedef struct packed {
		logic [KEY_W-1:0] same_key;
		logic [MAX_LEVEL-1:0][KEY_W-1:0] coarse_key;
		logic [MAX_LEVEL-1:0] coarse_en;
		logic [NFINE-1:0][KEY_W-1:0] fine_key;
		logic fine_en;
		logic reject;
	} cand_t;

	function automatic logic [KEY_W-1:0] pack_key(
		input logic [9:0] bi, input logic [9:0] bj, input logic [9:0] bk,
		input logic [3:0] lv,
		input logic [9:0] si, input logic [9:0] sj, input logic [9:0] sk);
		pack_key = {bi, bj, bk, lv, si, sj, sk};
	endfunction

endpackage

/* rtl/core/octree_face_neighbor_lookup.sv */
`timescale 1ns / 1ps
// octree face-neighbour lookup over a linear store of leaf keys
// input channel in_valid/in_ready carries one request: clear, insert or query.
// output channel out_valid/out_ready carries one result per request.
// configuration: cfg_we/cfg_index/cfg_wdata write grid_size_x/y/z (index 0..2);
// the user writes them only while the block is idle (not enforced); no read-back.
// an insert or query sweeps the key memory once, one entry per cycle, and
// compares each entry against all up to fifteen probe keys in parallel, then
// evaluates the result and loads it into the output register; clear, unused
// commands, rejected queries and any request on an empty store skip the sweep.
// one request is in flight at a time and the next can be taken in the cycle
// after the result is loaded.
// a result waits in the output register while out_ready is low; the block
// takes a new request meanwhile, but holds in ST_EVAL until it is delivered.
// reset empties the store (entry count to zero, memory contents are left as
// they are and never read beyond the count) and sets all grid sizes to one.
module octree_face_neighbor_lookup import ofnl_pkg::*; #(
	parameter int unsigned LEAF_CAPACITY = LEAF_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [9:0]  base_i,
	input  logic [9:0]  base_j,
	input  logic [9:0]  base_k,
	input  logic [3:0]  leaf_level,
	input  logic [9:0]  sub_i,
	input  logic [9:0]  sub_j,
	input  logic [9:0]  sub_k,
	input  logic [11:0] leaf_number,
	input  logic [2:0]  direction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [11:0] neighbor_index,
	output logic [3:0]  fine_valid,
	output logic [11:0] fine_index_0,
	output logic [11:0] fine_index_1,
	output logic [11:0] fine_index_2,
	output logic [11:0] fine_index_3,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(LEAF_CAPACITY);
	localparam int unsigned CW = $clog2(LEAF_CAPACITY + 1);

	state_t state_q, state_d;

	logic [KEY_W-1:0] key_mem [LEAF_CAPACITY];
	logic [IDX_W-1:0] idx_mem [LEAF_CAPACITY];

	logic [GRID_W-1:0] grid_x_q, grid_y_q, grid_z_q;
	logic [CW-1:0] entry_count_q;
	logic [AW-1:0] rd_addr_q;
	logic rd_vld_s1;
	logic [KEY_W-1:0] rd_key_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic [1:0] cmd_q;
	logic [9:0] base_i_q, base_j_q, base_k_q, sub_i_q, sub_j_q, sub_k_q;
	logic [3:0] level_q;
	logic [2:0] dir_q;
	logic [IDX_W-1:0] num_q;

	cand_t cand, cand_q;
	logic skip_q;
	logic [2:0] skip_kind_q;

	logic hit_same_q;
	logic [IDX_W-1:0] same_idx_q;
	logic [MAX_LEVEL-1:0] hit_co_q;
	logic [MAX_LEVEL-1:0][IDX_W-1:0] co_idx_q;
	logic [NFINE-1:0] hit_fi_q;
	logic [NFINE-1:0][IDX_W-1:0] fi_idx_q;

	logic out_valid_q;
	logic [2:0] kind_q;
	logic [IDX_W-1:0] nidx_q;
	logic [3:0] fvalid_q;
	logic [NFINE-1:0][IDX_W-1:0] fidx_q;

	logic is_probe, store_full, co_any, do_write, out_load, scan_last;
	logic [IDX_W-1:0] co_idx;
	logic [2:0] res_kind;
	logic [IDX_W-1:0] res_nidx;
	logic [3:0] res_fvalid;
	logic [NFINE-1:0][IDX_W-1:0] res_fidx;

	ofnl_cand u_cand (
		.command    (cmd_q),
		.base_i     (base_i_q),
		.base_j     (base_j_q),
		.base_k     (base_k_q),
		.leaf_level (level_q),
		.sub_i      (sub_i_q),
		.sub_j      (sub_j_q),
		.sub_k      (sub_k_q),
		.direction  (dir_q),
		.grid_x     (grid_x_q),
		.grid_y     (grid_y_q),
		.grid_z     (grid_z_q),
		.cand       (cand)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign is_probe = (cmd_q == CMD_INSERT) || (cmd_q == CMD_QUERY);
	assign store_full = entry_count_q >= CW'(LEAF_CAPACITY);
	assign scan_last = (CW'(rd_addr_q) + CW'(1)) == entry_count_q;
	assign out_load = (state_q == ST_EVAL) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (is_probe && !cand.reject && (entry_count_q != '0)) state_d = ST_SCAN;
				else state_d = ST_EVAL;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_EVAL;
			ST_EVAL: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= GRID_W'(1);
			grid_y_q <= GRID_W'(1);
			grid_z_q <= GRID_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_X: grid_x_q <= cfg_wdata;
				REG_GRID_Y: grid_y_q <= cfg_wdata;
				REG_GRID_Z: grid_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			base_i_q <= base_i;
			base_j_q <= base_j;
			base_k_q <= base_k;
			level_q <= leaf_level;
			sub_i_q <= sub_i;
			sub_j_q <= sub_j;
			sub_k_q <= sub_k;
			num_q <= leaf_number;
			dir_q <= direction;
		end
		if (state_q == ST_SETUP) begin
			cand_q <= cand;
			skip_q <= !is_probe || cand.reject;
			skip_kind_q <= ((cmd_q == CMD_QUERY) && cand.reject) ? KIND_OOG : KIND_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			rd_addr_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SETUP) rd_addr_q <= '0;
			else if (state_q == ST_SCAN) rd_addr_q <= rd_addr_q + AW'(1);
			if ((state_q == ST_SETUP) && (cmd_q == CMD_CLEAR)) entry_count_q <= '0;
			else if (out_load && do_write) entry_count_q <= entry_count_q + CW'(1);
		end
	end

	// key store, read one entry a cycle during the sweep; written only after it
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			rd_key_s1 <= key_mem[rd_addr_q];
			rd_idx_s1 <= idx_mem[rd_addr_q];
		end
		if (out_load && do_write) begin
			key_mem[entry_count_q[AW-1:0]] <= cand_q.same_key;
			idx_mem[entry_count_q[AW-1:0]] <= num_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_same_q <= 1'b0;
			hit_co_q <= '0;
			hit_fi_q <= '0;
			same_idx_q <= '0;
			co_idx_q <= '0;
			fi_idx_q <= '0;
		end else if (state_q == ST_SETUP) begin
			hit_same_q <= 1'b0;
			hit_co_q <= '0;
			hit_fi_q <= '0;
			same_idx_q <= '0;
			co_idx_q <= '0;
			fi_idx_q <= '0;
		end else if (rd_vld_s1) begin
			if (rd_key_s1 == cand_q.same_key) begin
				hit_same_q <= 1'b1;
				same_idx_q <= rd_idx_s1;
			end
			for (int m = 0; m < MAX_LEVEL; m++) begin
				if (cand_q.coarse_en[m] && (rd_key_s1 == cand_q.coarse_key[m])) begin
					hit_co_q[m] <= 1'b1;
					co_idx_q[m] <= rd_idx_s1;
				end
			end
			for (int q = 0; q < NFINE; q++) begin
				if (cand_q.fine_en && (rd_key_s1 == cand_q.fine_key[q])) begin
					hit_fi_q[q] <= 1'b1;
					fi_idx_q[q] <= rd_idx_s1;
				end
			end
		end
	end

	always_comb begin
		co_any = 1'b0;
		co_idx = '0;
		// nearest ancestor wins: highest level found
		for (int m = 0; m < MAX_LEVEL; m++) begin
			if (hit_co_q[m]) begin
				co_any = 1'b1;
				co_idx = co_idx_q[m];
			end
		end
		do_write = 1'b0;
		res_kind = KIND_DONE;
		res_nidx = '0;
		res_fvalid = '0;
		res_fidx = '0;
		if (skip_q) begin
			res_kind = skip_kind_q;
		end else if (cmd_q == CMD_INSERT) begin
			if (!hit_same_q) begin
				if (store_full) res_kind = KIND_FULL;
				else do_write = 1'b1;
			end
		end else if (hit_same_q) begin
			res_kind = KIND_SAME;
			res_nidx = same_idx_q;
		end else if (co_any) begin
			res_kind = KIND_COARSER;
			res_nidx = co_idx;
		end else if (hit_fi_q != '0) begin
			res_kind = KIND_FINER;
			res_fvalid = hit_fi_q;
			res_fidx = fi_idx_q;
		end else begin
			res_kind = KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= res_kind;
			nidx_q <= res_nidx;
			fvalid_q <= res_fvalid;
			fidx_q <= res_fidx;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign neighbor_index = nidx_q;
	assign fine_valid = fvalid_q;
	assign fine_index_0 = fidx_q[0];
	assign fine_index_1 = fidx_q[1];
	assign fine_index_2 = fidx_q[2];
	assign fine_index_3 = fidx_q[3];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(LEAF_CAPACITY))
		else $error("entry count beyond capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(rd_addr_q) < entry_count_q))
		else $error("sweep reads beyond written entries");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SETUP))
		else $error("accepted request did not enter setup");

	a_write_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && do_write) |-> (!hit_same_q && !store_full))
		else $error("store written with duplicate key or when full");

endmodule

/* rtl/core/ofnl_cand.sv */
`timescale 1ns / 1ps
module ofnl_cand import ofnl_pkg::*; (
	input  logic [1:0]        command,
	input  logic [9:0]        base_i,
	input  logic [9:0]        base_j,
	input  logic [9:0]        base_k,
	input  logic [3:0]        leaf_level,
	input  logic [9:0]        sub_i,
	input  logic [9:0]        sub_j,
	input  logic [9:0]        sub_k,
	input  logic [2:0]        direction,
	input  logic [GRID_W-1:0] grid_x,
	input  logic [GRID_W-1:0] grid_y,
	input  logic [GRID_W-1:0] grid_z,
	output cand_t             cand
);

	logic [10:0] mask_w;
	logic [9:0]  mask;
	logic [2:0][9:0]  sv;
	logic [2:0][10:0] bv;
	logic [2:0][GRID_W-1:0] grid;
	logic [2:0][9:0]  fp;
	logic [2:0][9:0]  cs;
	logic [1:0] ax, axd, axa;
	logic [3:0] sh;
	logic under, oog, offd, bitv;

	always_comb begin
		cand = '0;
		mask_w = (11'd1 << leaf_level) - 11'd1;
		mask = mask_w[9:0];
		sv[0] = sub_i & mask;
		sv[1] = sub_j & mask;
		sv[2] = sub_k & mask;
		bv[0] = {1'b0, base_i};
		bv[1] = {1'b0, base_j};
		bv[2] = {1'b0, base_k};
		grid[0] = grid_x;
		grid[1] = grid_y;
		grid[2] = grid_z;
		case (direction[2:1])
			2'd0: begin
				ax = 2'd2;
				axd = 2'd2;
				axa = 2'd0;
			end
			2'd1: begin
				ax = 2'd1;
				axd = 2'd1;
				axa = 2'd0;
			end
			default: begin
				ax = 2'd0;
				axd = 2'd0;
				axa = 2'd1;
			end
		endcase
		under = 1'b0;
		// one cell step along the normal, carrying into or borrowing from the adjacent base cell
		if (direction[0]) begin
			if (sv[ax] == mask) begin
				sv[ax] = '0;
				bv[ax] = bv[ax] + 11'd1;
			end else begin
				sv[ax] = sv[ax] + 10'd1;
			end
		end else begin
			if (sv[ax] == '0) begin
				sv[ax] = mask;
				if (bv[ax] == '0) under = 1'b1;
				else bv[ax] = bv[ax] - 11'd1;
			end else begin
				sv[ax] = sv[ax] - 10'd1;
			end
		end
		oog = under;
		for (int a = 0; a < 3; a++) begin
			if (bv[a] >= grid[a]) oog = 1'b1;
		end
		cand.reject = (leaf_level > 4'(MAX_LEVEL)) || (direction > 3'd5) || oog;
		cand.same_key = pack_key(bv[0][9:0], bv[1][9:0], bv[2][9:0], leaf_level,
			sv[0], sv[1], sv[2]);
		sh = '0;
		cs = '0;
		for (int m = 0; m < MAX_LEVEL; m++) begin
			sh = leaf_level - 4'(m);
			for (int a = 0; a < 3; a++) cs[a] = sv[a] >> sh;
			cand.coarse_en[m] = 4'(m) < leaf_level;
			cand.coarse_key[m] = pack_key(bv[0][9:0], bv[1][9:0], bv[2][9:0], 4'(m),
				cs[0], cs[1], cs[2]);
		end
		// face children one level down, on the side facing the query leaf
		offd = ~direction[0];
		cand.fine_en = leaf_level < 4'(MAX_LEVEL);
		fp = '0;
		bitv = 1'b0;
		for (int q = 0; q < NFINE; q++) begin
			for (int a = 0; a < 3; a++) begin
				if (2'(a) == axd) bitv = offd;
				else if (2'(a) == axa) bitv = q[0];
				else bitv = q[1];
				fp[a] = {sv[a][8:0], bitv};
			end
			cand.fine_key[q] = pack_key(bv[0][9:0], bv[1][9:0], bv[2][9:0],
				leaf_level + 4'd1, fp[0], fp[1], fp[2]);
		end
		if (command == CMD_INSERT) begin
			cand.same_key = pack_key(base_i, base_j, base_k, leaf_level, sub_i, sub_j, sub_k);
			cand.coarse_en = '0;
			cand.fine_en = 1'b0;
			cand.reject = 1'b0;
		end
	end

endmodule

/* tb/sv/octree_face_neighbor_lookup_test.sv */
`timescale 1ns / 1ps
module octree_face_neighbor_lookup_test;
	import ofnl_pkg::*;

	localparam int CAPACITY = 64;
	localparam int CYCLE_LIMIT = 2000000;

	localparam logic [2:0] DIR_ZN = 3'd0;
	localparam logic [2:0] DIR_ZP = 3'd1;
	localparam logic [2:0] DIR_YN = 3'd2;
	localparam logic [2:0] DIR_YP = 3'd3;
	localparam logic [2:0] DIR_XN = 3'd4;
	localparam logic [2:0] DIR_XP = 3'd5;
	localparam logic [2:0] DIR_BAD_LO = 3'd6;
	localparam logic [2:0] DIR_BAD_HI = 3'd7;

	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct {
		logic [1:0]  command;
		logic [9:0]  bi, bj, bk;
		logic [3:0]  lv;
		logic [9:0]  si, sj, sk;
		logic [11:0] num;
		logic [2:0]  dir;
	} request_t;

	typedef struct {
		logic [2:0]  kind;
		logic [11:0] nidx;
		logic [3:0]  fvalid;
		logic [11:0] fidx [4];
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = '0;
	logic [9:0] base_i = '0, base_j = '0, base_k = '0;
	logic [3:0] leaf_level = '0;
	logic [9:0] sub_i = '0, sub_j = '0, sub_k = '0;
	logic [11:0] leaf_number = '0;
	logic [2:0] direction = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic [11:0] neighbor_index;
	logic [3:0] fine_valid;
	logic [11:0] fine_index_0, fine_index_1, fine_index_2, fine_index_3;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [10:0] cfg_wdata = '0;

	octree_face_neighbor_lookup #(.LEAF_CAPACITY(CAPACITY)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .base_i(base_i), .base_j(base_j), .base_k(base_k),
		.leaf_level(leaf_level), .sub_i(sub_i), .sub_j(sub_j), .sub_k(sub_k),
		.leaf_number(leaf_number), .direction(direction),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .neighbor_index(neighbor_index), .fine_valid(fine_valid),
		.fine_index_0(fine_index_0), .fine_index_1(fine_index_1),
		.fine_index_2(fine_index_2), .fine_index_3(fine_index_3),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state
	logic [63:0] leaf_keys [CAPACITY];
	logic [11:0] leaf_ids [CAPACITY];
	int stored_leaves = 0;
	int grid [3] = '{1, 1, 1};

	request_t requests_pending [$];
	lookup_t lookups_expected [$];
	request_t leaf_pool [$];
	int failures = 0;
	int cycles = 0;

	function automatic logic [63:0] leaf_key(int bi, int bj, int bk, int lv,
			int si, int sj, int sk);
		return {bi[9:0], bj[9:0], bk[9:0], lv[3:0], si[9:0], sj[9:0], sk[9:0]};
	endfunction

	function automatic bit find_leaf(logic [63:0] key, output logic [11:0] id);
		id = '0;
		for (int i = 0; i < stored_leaves; i++) begin
			if (leaf_keys[i] == key) begin
				id = leaf_ids[i];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic lookup_t face_query(request_t q);
		lookup_t r;
		int lv, d, mask, ax, axa, axb, offd, sh;
		int b [3];
		int s [3];
		int fp [3];
		logic [11:0] id;
		r.kind = KIND_NONE;
		r.nidx = '0;
		r.fvalid = '0;
		for (int i = 0; i < 4; i++) r.fidx[i] = '0;
		lv = int'(q.lv);
		d = int'(q.dir);
		if (lv > MAX_LEVEL || d > 5) begin
			r.kind = KIND_OOG;
			return r;
		end
		mask = (1 << lv) - 1;
		b = '{int'(q.bi), int'(q.bj), int'(q.bk)};
		s = '{int'(q.si) & mask, int'(q.sj) & mask, int'(q.sk) & mask};
		ax = 2 - (d >> 1);
		if (d % 2 == 1) begin
			if (s[ax] == mask) begin
				s[ax] = 0;
				b[ax]++;
			end else s[ax]++;
		end else begin
			if (s[ax] == 0) begin
				s[ax] = mask;
				b[ax]--;
			end else s[ax]--;
		end
		for (int a = 0; a < 3; a++) begin
			if (b[a] < 0 || b[a] >= grid[a]) begin
				r.kind = KIND_OOG;
				return r;
			end
		end
		if (find_leaf(leaf_key(b[0], b[1], b[2], lv, s[0], s[1], s[2]), id)) begin
			r.kind = KIND_SAME;
			r.nidx = id;
			return r;
		end
		// ancestors, nearest first
		for (int lq = lv; lq > 0; lq--) begin
			sh = lv - (lq - 1);
			if (find_leaf(leaf_key(b[0], b[1], b[2], lq - 1,
					s[0] >> sh, s[1] >> sh, s[2] >> sh), id)) begin
				r.kind = KIND_COARSER;
				r.nidx = id;
				return r;
			end
		end
		if (lv < MAX_LEVEL) begin
			axa = (ax == 0) ? 1 : 0;
			axb = (ax == 2) ? 1 : 2;
			offd = (d % 2 == 1) ? 0 : 1;
			for (int rr = 0; rr < 2; rr++) begin
				for (int cc = 0; cc < 2; cc++) begin
					fp[ax] = 2 * s[ax] + offd;
					fp[axa] = 2 * s[axa] + cc;
					fp[axb] = 2 * s[axb] + rr;
					if (find_leaf(leaf_key(b[0], b[1], b[2], lv + 1,
							fp[0], fp[1], fp[2]), id)) begin
						r.fvalid[rr * 2 + cc] = 1'b1;
						r.fidx[rr * 2 + cc] = id;
					end
				end
			end
		end
		r.kind = (r.fvalid != 0) ? KIND_FINER : KIND_NONE;
		return r;
	endfunction

	function automatic lookup_t neighbor_lookup(request_t q);
		lookup_t r;
		logic [63:0] key;
		logic [11:0] id;
		r.kind = KIND_DONE;
		r.nidx = '0;
		r.fvalid = '0;
		for (int i = 0; i < 4; i++) r.fidx[i] = '0;
		case (q.command)
			CMD_CLEAR: begin
				stored_leaves = 0;
			end
			CMD_INSERT: begin
				key = leaf_key(q.bi, q.bj, q.bk, q.lv, q.si, q.sj, q.sk);
				if (!find_leaf(key, id)) begin
					if (stored_leaves >= CAPACITY) r.kind = KIND_FULL;
					else begin
						leaf_keys[stored_leaves] = key;
						leaf_ids[stored_leaves] = q.num;
						stored_leaves++;
					end
				end
			end
			CMD_QUERY: r = face_query(q);
			default: ;
		endcase
		return r;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// request driver
	request_t cur;
	int send_gap = 0;
	bit send_burst = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				lookups_expected.insert(lookups_expected.size(), neighbor_lookup(cur));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (requests_pending.size() > 0) begin
					cur = requests_pending.pop_front();
					command <= cur.command;
					base_i <= cur.bi;
					base_j <= cur.bj;
					base_k <= cur.bk;
					leaf_level <= cur.lv;
					sub_i <= cur.si;
					sub_j <= cur.sj;
					sub_k <= cur.sk;
					leaf_number <= cur.num;
					direction <= cur.dir;
					in_valid <= 1'b1;
					if ($urandom_range(0, 79) == 0) send_burst = !send_burst;
					send_gap = send_burst ? 0 : gap_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		lookup_t e;
		logic [11:0] got [4];
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{fine_index_0, fine_index_1, fine_index_2, fine_index_3};
				if (lookups_expected.size() == 0) begin
					$display("%0t: result with nothing expected, kind %0d", $time, kind);
					failures++;
				end else begin
					e = lookups_expected.pop_front();
					if (kind !== e.kind) begin
						$display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
						failures++;
					end
					if (neighbor_index !== e.nidx) begin
						$display("%0t: neighbor_index expected %0d actual %0d",
							$time, e.nidx, neighbor_index);
						failures++;
					end
					if (fine_valid !== e.fvalid) begin
						$display("%0t: fine_valid expected %b actual %b",
							$time, e.fvalid, fine_valid);
						failures++;
					end
					for (int i = 0; i < 4; i++) begin
						if (got[i] !== e.fidx[i]) begin
							$display("%0t: fine_index_%0d expected %0d actual %0d",
								$time, i, e.fidx[i], got[i]);
							failures++;
						end
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall = gap_length();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic add(logic [1:0] c, int bi, int bj, int bk, int lv,
			int si, int sj, int sk, int num, logic [2:0] d);
		request_t q;
		q.command = c;
		q.bi = 10'(bi);
		q.bj = 10'(bj);
		q.bk = 10'(bk);
		q.lv = 4'(lv);
		q.si = 10'(si);
		q.sj = 10'(sj);
		q.sk = 10'(sk);
		q.num = 12'(num);
		q.dir = d;
		requests_pending.insert(requests_pending.size(), q);
	endtask

	// sampled away from the active edge so that pending updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (requests_pending.size() != 0 || in_valid || lookups_expected.size() != 0)
			@(negedge clk);
		repeat (CAPACITY + 16) @(posedge clk);
	endtask

	task automatic write_grid(logic [1:0] idx, int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 11'(v);
		grid[idx] = v & 11'h7FF;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_base(int g);
		int r;
		r = $urandom_range(0, 3);
		if (r == 0) return 0;
		if (r == 1) return (g > 1024 ? 1024 : g) - 1;
		return $urandom_range(0, (g < 3 ? g : 3) - 1);
	endfunction

	function automatic request_t random_leaf();
		request_t q;
		int lv;
		lv = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 10);
		q.command = CMD_INSERT;
		q.bi = 10'(pick_base(grid[0]));
		q.bj = 10'(pick_base(grid[1]));
		q.bk = 10'(pick_base(grid[2]));
		q.lv = 4'(lv);
		q.si = 10'($urandom & ((1 << lv) - 1));
		q.sj = 10'($urandom & ((1 << lv) - 1));
		q.sk = 10'($urandom & ((1 << lv) - 1));
		q.num = 12'($urandom);
		q.dir = 3'($urandom_range(0, 5));
		return q;
	endfunction

	task automatic random_phase(int gx, int gy, int gz, int clear_pct, int count);
		request_t q;
		int r;
		wait_idle();
		write_grid(REG_GRID_X, gx);
		write_grid(REG_GRID_Y, gy);
		write_grid(REG_GRID_Z, gz);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < clear_pct) begin
				q = random_leaf();
				q.command = CMD_CLEAR;
				leaf_pool.delete();
			end else if (r >= 90) begin
				// noise: every field at random
				q.command = 2'($urandom_range(0, 3));
				{q.bi, q.bj, q.bk, q.lv} = 34'({$urandom, $urandom});
				{q.si, q.sj, q.sk, q.num, q.dir} = 45'({$urandom, $urandom});
				if (q.command == CMD_CLEAR) leaf_pool.delete();
			end else if (r < 50 || leaf_pool.size() == 0) begin
				q = random_leaf();
				leaf_pool.insert(leaf_pool.size(), q);
			end else begin
				q = leaf_pool[$urandom_range(0, leaf_pool.size() - 1)];
				q.command = CMD_QUERY;
				q.dir = 3'($urandom_range(0, 5));
				q.num = 12'($urandom);
			end
			requests_pending.insert(requests_pending.size(), q);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_grid(REG_GRID_X, 1024);
		write_grid(REG_GRID_Y, 1024);
		write_grid(REG_GRID_Z, 1024);
		add(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, DIR_ZN);
		add(CMD_INSERT, 1023, 1023, 1023, 10, 1023, 1023, 1023, 4095, DIR_ZN);
		// a second insert of the same key is ignored
		add(CMD_INSERT, 1023, 1023, 1023, 10, 1023, 1023, 1023, 1, DIR_ZN);
		// carry past the upper grid edge
		add(CMD_QUERY, 1023, 1023, 1023, 10, 1023, 1023, 1023, 0, DIR_XP);
		add(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0, 0, DIR_ZN);
		add(CMD_INSERT, 1, 0, 0, 0, 0, 0, 0, 7, DIR_ZN);
		add(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, DIR_XP);
		add(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, DIR_XN);
		add(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, DIR_YN);
		add(CMD_INSERT, 0, 0, 1, 1, 0, 0, 0, 10, DIR_ZN);
		add(CMD_INSERT, 0, 0, 1, 1, 1, 1, 0, 11, DIR_ZN);
		add(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, DIR_ZP);
		// high sub bits are masked off, neighbour found one level up
		add(CMD_QUERY, 1, 0, 0, 1, 1022, 0, 0, 0, DIR_XP);
		add(CMD_QUERY, 0, 0, 1, 1, 1, 1, 1, 0, DIR_ZN);
		add(CMD_QUERY, 5, 5, 5, 10, 3, 4, 5, 0, DIR_ZN);
		add(CMD_QUERY, 5, 5, 5, 0, 0, 0, 0, 0, DIR_YP);
		add(CMD_QUERY, 5, 5, 5, 11, 0, 0, 0, 0, DIR_ZN);
		add(CMD_QUERY, 5, 5, 5, 15, 0, 0, 0, 0, DIR_ZN);
		add(CMD_QUERY, 5, 5, 5, 1, 0, 0, 0, 0, DIR_BAD_LO);
		add(CMD_QUERY, 5, 5, 5, 1, 0, 0, 0, 0, DIR_BAD_HI);
		add(CMD_SPARE, 1023, 1023, 1023, 15, 1023, 1023, 1023, 4095, DIR_BAD_HI);
		add(CMD_INSERT, 2, 0, 0, 3, 1023, 1023, 1023, 4095, DIR_ZN);

		random_phase(1, 1, 2, 3, 300);
		random_phase(2, 2, 2, 1, 300);
		random_phase(1024, 1024, 1024, 2, 300);
		// no clears planned here, only those from random noise, so the store can fill up
		random_phase(1, 3, 1024, 0, 300);

		wait_idle();
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
